// ===== rtl/prt_pkg.sv =====
// ----------------------------------------------------------------------------
// prt_pkg: shared types for the primitive root test
// Command and status groups between controller and datapath, operand selects.
// ----------------------------------------------------------------------------
package prt_pkg;

  typedef enum logic [1:0] {
    DIV_GP   = 2'd0,
    DIV_REST = 2'd1,
    DIV_EXP  = 2'd2
  } div_sel_e;

  typedef enum logic [1:0] {
    Q_TWO  = 2'd0,
    Q_D    = 2'd1,
    Q_REST = 2'd2
  } q_sel_e;

  typedef enum logic {
    MUL_ACC = 1'b0,
    MUL_SQR = 1'b1
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     g_from_rem;
    logic     rest_init;
    logic     rest_shift;
    logic     rest_from_quot;
    logic     seen_set;
    logic     seen_clr;
    logic     q_load;
    q_sel_e   q_sel;
    logic     d_init;
    logic     d_inc;
    logic     pow_init;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     mul_wb;
    logic     ex_shift;
    logic     res_load;
    logic     res_val;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic mul_done;
    logic mul_busy;
    logic p_lt2;
    logic trivial;
    logic rem_zero;
    logic rest_even_nz;
    logic d_gt_quot;
    logic seen;
    logic ex_zero;
    logic ex_odd;
    logic acc_one;
    logic rest_gt1;
  } sts_t;

endpackage

// ===== rtl/prt_div.sv =====
// ----------------------------------------------------------------------------
// prt_div: iterative restoring divider
// One quotient bit per cycle; quotient and remainder held after done.
// ----------------------------------------------------------------------------
module prt_div #(
  parameter int WIDTH = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] num_i,
  input  logic [WIDTH-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [WIDTH-1:0] quo_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] quo_q, quo_d, rem_q, rem_d, den_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WIDTH:0]   sh;
  logic             fit;

  assign sh  = {rem_q, quo_q[WIDTH-1]};
  assign fit = sh >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[WIDTH-2:0], fit};
      rem_d = fit ? WIDTH'(sh - {1'b0, den_q}) : sh[WIDTH-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/prt_mulmod.sv =====
// ----------------------------------------------------------------------------
// prt_mulmod: shift-and-add modular multiplier
// One multiplier bit per cycle, stops when the multiplier runs out of ones.
// ----------------------------------------------------------------------------
module prt_mulmod #(
  parameter int WIDTH = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  logic [WIDTH-1:0] acc_q, acc_d, a_q, a_d, b_q, b_d, m_q;
  logic             busy_q, busy_d, done_q, done_d;

  // x, y < m
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] gap;
    gap = m - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (b_q[0]) acc_d = add_mod(acc_q, a_q, m_q);
        a_d = add_mod(a_q, a_q, m_q);
        b_d = b_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    if (start_i) m_q <= m_i;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/prt_datapath.sv =====
// ----------------------------------------------------------------------------
// prt_datapath: operand registers, divider and modular multiplier
// Executes controller commands and reports flags back.
// ----------------------------------------------------------------------------
module prt_datapath
  import prt_pkg::*;
#(
  parameter int WIDTH = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [WIDTH-1:0] g_i,
  input  logic [WIDTH-1:0] p_i,
  output sts_t             sts_o,
  output logic             is_generator_o
);

  logic [WIDTH-1:0] g_q, p_q, rest_q, d_q, q_q, ex_q, acc_q, base_q;
  logic             seen_q, res_q;
  logic [WIDTH-1:0] div_num, div_den, div_quo, div_rem;
  logic [WIDTH-1:0] mul_a, mul_b, mul_prod;
  logic             div_busy, div_done, mul_busy, mul_done;

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_GP: begin
        div_num = g_q;
        div_den = p_q;
      end
      DIV_REST: begin
        div_num = rest_q;
        div_den = d_q;
      end
      default: begin
        div_num = p_q - WIDTH'(1);
        div_den = q_q;
      end
    endcase
  end

  assign mul_a = (cmd_i.mul_sel == MUL_ACC) ? acc_q : base_q;
  assign mul_b = base_q;

  prt_div #(.WIDTH(WIDTH)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  prt_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (p_q),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      g_q <= g_i;
      p_q <= p_i;
    end else if (cmd_i.g_from_rem) begin
      g_q <= div_rem;
    end
    if (cmd_i.rest_init) rest_q <= p_q - WIDTH'(1);
    else if (cmd_i.rest_shift) rest_q <= rest_q >> 1;
    else if (cmd_i.rest_from_quot) rest_q <= div_quo;
    if (cmd_i.d_init) d_q <= WIDTH'(3);
    else if (cmd_i.d_inc) d_q <= d_q + WIDTH'(2);
    if (cmd_i.seen_set) seen_q <= 1'b1;
    else if (cmd_i.seen_clr) seen_q <= 1'b0;
    if (cmd_i.q_load) begin
      unique case (cmd_i.q_sel)
        Q_TWO:   q_q <= WIDTH'(2);
        Q_D:     q_q <= d_q;
        default: q_q <= rest_q;
      endcase
    end
    if (cmd_i.pow_init) begin
      acc_q  <= WIDTH'(1);
      base_q <= g_q;
      ex_q   <= div_quo;
    end else begin
      if (cmd_i.mul_wb && cmd_i.mul_sel == MUL_ACC) acc_q <= mul_prod;
      if (cmd_i.mul_wb && cmd_i.mul_sel == MUL_SQR) base_q <= mul_prod;
      if (cmd_i.ex_shift) ex_q <= ex_q >> 1;
    end
    if (cmd_i.res_load) res_q <= cmd_i.res_val;
  end

  assign sts_o.div_done     = div_done;
  assign sts_o.div_busy     = div_busy;
  assign sts_o.mul_done     = mul_done;
  assign sts_o.mul_busy     = mul_busy;
  assign sts_o.p_lt2        = (p_q >> 1) == '0;
  assign sts_o.trivial      = (g_q == WIDTH'(1)) && (p_q == WIDTH'(2));
  assign sts_o.rem_zero     = div_rem == '0;
  assign sts_o.rest_even_nz = (rest_q != '0) && !rest_q[0];
  assign sts_o.d_gt_quot    = d_q > div_quo;
  assign sts_o.seen         = seen_q;
  assign sts_o.ex_zero      = ex_q == '0;
  assign sts_o.ex_odd       = ex_q[0];
  assign sts_o.acc_one      = acc_q == WIDTH'(1);
  assign sts_o.rest_gt1     = (rest_q >> 1) != '0;

  assign is_generator_o = res_q;

endmodule

// ===== rtl/prt_ctrl.sv =====
// ----------------------------------------------------------------------------
// prt_ctrl: sequencer for the primitive root test
// Walks trial division of p-1 and one power test per distinct prime factor.
// ----------------------------------------------------------------------------
module prt_ctrl
  import prt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_CHECK   = 14'b00000000000010,
    S_GMOD_W  = 14'b00000000000100,
    S_TWO     = 14'b00000000001000,
    S_TOP_S   = 14'b00000000010000,
    S_TOP_W   = 14'b00000000100000,
    S_INNER_S = 14'b00000001000000,
    S_INNER_W = 14'b00000010000000,
    S_EXP_S   = 14'b00000100000000,
    S_EXP_W   = 14'b00001000000000,
    S_POW     = 14'b00010000000000,
    S_MULA_W  = 14'b00100000000000,
    S_MULS_S  = 14'b01000000000000,
    S_DONE    = 14'b10000000000000
  } state_e;

  typedef enum logic [1:0] {
    RET_TWO  = 2'd0,
    RET_D    = 2'd1,
    RET_LEFT = 2'd2
  } ret_e;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  logic   muls_w_q, muls_w_d;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    muls_w_d    = muls_w_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.p_lt2) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.trivial) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_val  = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_GP;
          state_d         = S_GMOD_W;
        end
      end
      S_GMOD_W: begin
        if (sts_i.div_done) begin
          if (sts_i.rem_zero) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.g_from_rem = 1'b1;
            cmd_o.rest_init  = 1'b1;
            cmd_o.seen_clr   = 1'b1;
            state_d          = S_TWO;
          end
        end
      end
      S_TWO: begin
        if (sts_i.rest_even_nz) begin
          cmd_o.rest_shift = 1'b1;
          cmd_o.seen_set   = 1'b1;
        end else if (sts_i.seen) begin
          cmd_o.q_load = 1'b1;
          cmd_o.q_sel  = Q_TWO;
          ret_d        = RET_TWO;
          state_d      = S_EXP_S;
        end else begin
          cmd_o.d_init = 1'b1;
          state_d      = S_TOP_S;
        end
      end
      S_TOP_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_REST;
        state_d         = S_TOP_W;
      end
      S_TOP_W: begin
        cmd_o.div_sel = DIV_REST;
        if (sts_i.div_done) begin
          if (sts_i.d_gt_quot) begin
            if (sts_i.rest_gt1) begin
              cmd_o.q_load = 1'b1;
              cmd_o.q_sel  = Q_REST;
              ret_d        = RET_LEFT;
              state_d      = S_EXP_S;
            end else begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_val  = 1'b1;
              state_d        = S_DONE;
            end
          end else if (sts_i.rem_zero) begin
            cmd_o.seen_set       = 1'b1;
            cmd_o.rest_from_quot = 1'b1;
            state_d              = S_INNER_S;
          end else begin
            cmd_o.d_inc = 1'b1;
            state_d     = S_TOP_S;
          end
        end
      end
      S_INNER_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_REST;
        state_d         = S_INNER_W;
      end
      S_INNER_W: begin
        if (sts_i.div_done) begin
          if (sts_i.rem_zero) begin
            cmd_o.rest_from_quot = 1'b1;
            state_d              = S_INNER_S;
          end else begin
            cmd_o.q_load = 1'b1;
            cmd_o.q_sel  = Q_D;
            ret_d        = RET_D;
            state_d      = S_EXP_S;
          end
        end
      end
      S_EXP_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_EXP;
        state_d         = S_EXP_W;
      end
      S_EXP_W: begin
        if (sts_i.div_done) begin
          cmd_o.pow_init = 1'b1;
          state_d        = S_POW;
        end
      end
      S_POW: begin
        if (sts_i.ex_zero) begin
          if (sts_i.acc_one) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_DONE;
          end else begin
            unique case (ret_q)
              RET_TWO: begin
                cmd_o.seen_clr = 1'b1;
                cmd_o.d_init   = 1'b1;
                state_d        = S_TOP_S;
              end
              RET_D: begin
                cmd_o.seen_clr = 1'b1;
                cmd_o.d_inc    = 1'b1;
                state_d        = S_TOP_S;
              end
              default: begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_val  = 1'b1;
                state_d        = S_DONE;
              end
            endcase
          end
        end else if (sts_i.ex_odd) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_ACC;
          state_d         = S_MULA_W;
        end else begin
          cmd_o.mul_sel = MUL_SQR;
          state_d       = S_MULS_S;
          muls_w_d      = 1'b0;
        end
      end
      S_MULA_W: begin
        cmd_o.mul_sel = MUL_ACC;
        if (sts_i.mul_done) begin
          cmd_o.mul_wb = 1'b1;
          state_d      = S_MULS_S;
          muls_w_d     = 1'b0;
        end
      end
      S_MULS_S: begin
        // first pass starts the squaring, second waits for it
        cmd_o.mul_sel = MUL_SQR;
        if (!muls_w_q) begin
          cmd_o.mul_start = 1'b1;
          muls_w_d        = 1'b1;
        end else if (sts_i.mul_done) begin
          cmd_o.mul_wb   = 1'b1;
          cmd_o.ex_shift = 1'b1;
          state_d        = S_POW;
        end
      end
      S_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= RET_TWO;
      muls_w_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      muls_w_q <= muls_w_d;
    end
  end

endmodule

// ===== rtl/primitive_root_test.sv =====
// ----------------------------------------------------------------------------
// primitive_root_test: primitive root test modulo a prime
// Factors p-1 by trial division and checks g^((p-1)/q) mod p != 1 for each
// distinct prime factor q; answers 1 when g generates the group mod p.
//
//   channel   dir  tdata (low bit up)            tuser  tlast
//   s_axis    in   g[W-1:0], p[W-1:0], zero pad  -      -
//   m_axis    out  is_generator, zero pad        -      -
//
// Work: one word at a time. Each trial divisor costs a division on the shared
// restoring divider; each prime factor adds a division and then, per exponent
// bit, a squaring and, when the bit is set, a multiply. For 30-bit p the trial
// division loop dominates in the worst case.
// Reset clears the sequencer and the control state of the divider and the
// multiplier only. The result word holds until taken; a new input word is
// accepted only once the result has left.
// ----------------------------------------------------------------------------
module primitive_root_test
  import prt_pkg::*;
#(
  parameter int WIDTH = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [((2*WIDTH+7)/8)*8-1:0] s_axis_tdata,  // g, p
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata    // is_generator
);

  cmd_t cmd;
  sts_t sts;
  logic is_generator;

  // sequencer: handshakes and command issue
  prt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // operands, divider and multiplier
  prt_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .g_i            (s_axis_tdata[WIDTH-1:0]),
    .p_i            (s_axis_tdata[2*WIDTH-1:WIDTH]),
    .sts_o          (sts),
    .is_generator_o (is_generator)
  );

  // pad the single result bit to a byte
  assign m_axis_tdata = {7'b0, is_generator};

`ifndef SYNTH
  // never take a word while a result is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready stayed high after accept");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier restarted while busy");
`endif

endmodule

// ===== tb/primitive_root_test_test.sv =====
// ----------------------------------------------------------------------------
// primitive_root_test_test: self-checking bench for the primitive root test
// Streams (g, p) words into the block and checks each is_generator word
// against an in-bench computation: trial-factor p-1 and test the powers
// g^((p-1)/q) mod p. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module primitive_root_test_test;

  localparam int  WIDTH      = 30;
  localparam int  DW         = ((2*WIDTH+7)/8)*8;
  localparam int  N_RANDOM   = 100;
  localparam int  CALM_TAIL  = 20;      // last words go without idling
  localparam int  LONG_HOLD  = 20000;   // receiver hold-off, in cycles
  localparam int  HOLD_AT    = 30;      // start the hold-off after this many words
  localparam int  DRAIN_TAIL = 400;     // cycles after the last result
  localparam longint CYCLE_LIMIT = 8000000;
  localparam logic [WIDTH-1:0] FMAX = {WIDTH{1'b1}};

  typedef struct {
    logic [WIDTH-1:0] g;
    logic [WIDTH-1:0] p;
    bit               drain_first;  // wait for every result before offering
    bit               calm;         // no idling around this word
  } cand_t;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [DW-1:0] s_axis_tdata  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [7:0]    m_axis_tdata;

  primitive_root_test #(.WIDTH(WIDTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // g, p
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // is_generator
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cand_t  pending_cands[$];
  bit     expected_gen[$];
  cand_t  current_cand;
  bit     current_calm = 1'b0;
  bit     word_taken   = 1'b0;
  int     words_in     = 0;
  int     words_total  = 0;
  int     mismatches   = 0;
  longint cycles       = 0;

  // --------------------------------------------------------------------------
  // Arithmetic for the expected answer
  // --------------------------------------------------------------------------
  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                             longint unsigned m);
    longint unsigned acc;
    acc = 0;
    // shift-and-add; every partial sum stays below m
    while (b != 0) begin
      if (b[0]) acc = (acc >= m - a) ? acc - (m - a) : acc + a;
      a = (a >= m - a) ? a - (m - a) : a + a;
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic bit power_hits_one(longint unsigned g, longint unsigned p,
                                        longint unsigned q);
    longint unsigned acc, base, ex;
    acc  = 1;
    base = g;
    ex   = (p - 1) / q;
    while (ex != 0) begin
      if (ex[0]) acc = mulmod(acc, base, p);
      base = mulmod(base, base, p);
      ex   = ex >> 1;
    end
    return acc == 1;
  endfunction

  function automatic bit generator_of(logic [WIDTH-1:0] g_in, logic [WIDTH-1:0] p_in);
    longint unsigned g, p, rest, d;
    bit              seen;
    g = g_in;
    p = p_in;
    if (p < 2) return 1'b0;
    if (g == 1 && p == 2) return 1'b1;
    g = g % p;
    if (g == 0) return 1'b0;
    rest = p - 1;
    seen = 1'b0;
    while (rest != 0 && rest[0] == 1'b0) begin
      seen = 1'b1;
      rest = rest >> 1;
    end
    if (seen && power_hits_one(g, p, 2)) return 1'b0;
    for (d = 3; d <= rest / d; d += 2) begin
      seen = 1'b0;
      while (rest % d == 0) begin
        seen = 1'b1;
        rest = rest / d;
      end
      if (seen && power_hits_one(g, p, d)) return 1'b0;
    end
    if (rest > 1 && power_hits_one(g, p, rest)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit is_prime(int unsigned n);
    if (n < 2) return 1'b0;
    for (int unsigned k = 2; k * k <= n; k++)
      if (n % k == 0) return 1'b0;
    return 1'b1;
  endfunction

  task automatic queue_cand(logic [WIDTH-1:0] g, logic [WIDTH-1:0] p, bit drain_first);
    cand_t c;
    c.g = g;
    c.p = p;
    c.drain_first = drain_first;
    c.calm = 1'b0;
    pending_cands.push_back(c);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pp, m, k;
    logic [WIDTH-1:0] gg;
    // directed words: trivial group, modulus below two, g equal to p / multiple / above p
    queue_cand(1, 2, 0);
    queue_cand(1, 0, 0);
    queue_cand(3, 1, 0);
    queue_cand(FMAX, 0, 0);
    queue_cand(1, 3, 0);
    queue_cand(2, 3, 0);
    queue_cand(2, 5, 0);
    queue_cand(4, 5, 0);
    queue_cand(3, 7, 0);
    queue_cand(2, 7, 0);
    queue_cand(5, 5, 0);
    queue_cand(10, 5, 0);
    queue_cand(7, 5, 0);
    queue_cand(FMAX - 1, 2, 0);
    queue_cand(2, 15, 0);          // composite modulus
    queue_cand(3, 65537, 0);
    queue_cand(3, 1048577, 0);     // 2^20+1, composite
    queue_cand(FMAX - 1, FMAX, 0); // field maxima
    queue_cand(FMAX, FMAX, 0);
    queue_cand(2, FMAX, 0);
    queue_cand(1, FMAX, 0);
    // random words: mostly prime moduli with a proper candidate
    for (int i = 0; i < N_RANDOM; i++) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        do pp = $urandom_range(3, 16383); while (!is_prime(pp));
        gg = WIDTH'($urandom_range(1, pp - 1));
      end else if (k < 8) begin
        // wide modulus with smooth p-1 keeps the factoring short
        m  = $urandom_range(1, 4095);
        k  = $urandom_range(0, WIDTH - 1);
        pp = ((m << k) & FMAX) + 1;
        gg = WIDTH'($urandom() & FMAX);
      end else begin
        pp = $urandom_range(0, 4095);
        gg = WIDTH'($urandom() & FMAX);
      end
      // one pause for a full drain in the middle of the run
      queue_cand(gg, pp[WIDTH-1:0], i == N_RANDOM / 2);
    end
    for (int i = pending_cands.size() - CALM_TAIL; i < pending_cands.size(); i++)
      pending_cands[i].calm = 1'b1;
    words_total = pending_cands.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (words_in == words_total && expected_gen.size() == 0);
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (mismatches == 0 && expected_gen.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: change inputs at the falling edge
  // --------------------------------------------------------------------------
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cands.size() == 0 ||
                   (pending_cands[0].drain_first && expected_gen.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        current_cand = pending_cands.pop_front();
        s_axis_tdata  <= {{(DW-2*WIDTH){1'b0}}, current_cand.p, current_cand.g};
        s_axis_tvalid <= 1'b1;
        // occasional idle burst after this word
        if (!current_cand.calm && $urandom_range(0, 3) == 0)
          gap_left <= $urandom_range(1, 4);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off to back up the block
  // --------------------------------------------------------------------------
  int  hold_left = 0;
  bit  held_once = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (!held_once && words_in >= HOLD_AT) begin
      held_once <= 1'b1;
      hold_left <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!current_calm && $urandom_range(0, 4) == 0) begin
      hold_left <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    word_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_gen.push_back(generator_of(s_axis_tdata[WIDTH-1:0],
                                          s_axis_tdata[2*WIDTH-1:WIDTH]));
      words_in <= words_in + 1;
      if (words_in + 1 >= words_total - CALM_TAIL) current_calm <= 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_gen.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result word: is_generator=%0b", m_axis_tdata[0]);
      end else if (expected_gen[0] !== m_axis_tdata[0]) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("is_generator mismatch: expected %0b, got %0b",
                   expected_gen[0], m_axis_tdata[0]);
        void'(expected_gen.pop_front());
      end else begin
        void'(expected_gen.pop_front());
      end
    end
  end

endmodule

// ===== primitive_root_test.f =====
rtl/prt_pkg.sv
rtl/prt_div.sv
rtl/prt_mulmod.sv
rtl/prt_datapath.sv
rtl/prt_ctrl.sv
rtl/primitive_root_test.sv
tb/primitive_root_test_test.sv
